FILE: rtl/tss_pkg.sv
package tss_pkg;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_ADD  = 1'b1
  } op_t;

  typedef struct packed {
    logic               operation;
    logic [1:0]         axis;
    logic signed [15:0] steps;
  } cmd_t;

  typedef struct packed {
    logic [5:0] coil_pattern;
    logic       idle;
  } res_t;

  localparam int LATCH_PAIRS = 3;

  function automatic logic [1:0] gray_code(input logic [1:0] phase);
    logic [1:0] code;
    case (phase)
      2'd0:    code = 2'd0;
      2'd1:    code = 2'd1;
      2'd2:    code = 2'd3;
      2'd3:    code = 2'd2;
      default: code = 2'd0;
    endcase
    return code;
  endfunction

endpackage

FILE: rtl/three_axis_stepper_sequencer.sv
// A tick beat moves from S_IDLE to S_FINISH, which registers its result once no held result is stalled.
// A command beat for a valid axis passes through S_ADD and S_SCAN, then, for each axis,
// S_DIV_LOAD and, when its remaining count is non-zero, S_DIV_RUN, where the one shared
// bit-serial divider works out each period in turn; it then ends in S_FINISH.
// Throughput: one beat at a time; the next beat is taken while a result awaits collection.
// Reset clears every count, phase, counter and the coil latch, and sets every period to 1.
module three_axis_stepper_sequencer
  import tss_pkg::*;
#(
  parameter int AXIS_COUNT  = 3,
  parameter int COUNT_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  localparam int CW    = COUNT_WIDTH;
  localparam int IDX_W = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
  localparam int SUM_W = ((CW > 16) ? CW : 16) + 1;
  localparam int BIT_W = $clog2(CW + 1);
  localparam int PAD   = (AXIS_COUNT > LATCH_PAIRS) ? AXIS_COUNT : LATCH_PAIRS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(AXIS_COUNT - 1);
  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_SCAN,
    S_DIV_LOAD,
    S_DIV_RUN,
    S_FINISH
  } state_t;

  function automatic logic [CW-1:0] magnitude(input logic [CW-1:0] v);
    return v[CW-1] ? (~v + 1'b1) : v;
  endfunction

  state_t state;
  logic [IDX_W-1:0] idx;
  logic signed [15:0] add_steps;
  logic [1:0] phase [AXIS_COUNT];
  logic signed [CW-1:0] remaining [AXIS_COUNT];
  logic [CW-1:0] counter [AXIS_COUNT];
  logic [CW-1:0] period [AXIS_COUNT];
  logic [5:0] coil_latch;
  logic [CW-1:0] top;
  logic [CW-1:0] divisor;
  logic [CW-1:0] partial;
  logic [CW-1:0] quotient;
  logic [BIT_W-1:0] bits_left;

  logic [CW-1:0] cur_mag;
  logic signed [SUM_W-1:0] sum;
  logic signed [CW-1:0] sat_sum;
  logic [CW:0] shifted;
  logic [CW:0] trial;
  logic [CW-1:0] partial_next;
  logic [CW-1:0] quotient_next;
  logic all_idle;
  logic is_last;

  logic [1:0] tick_phase [AXIS_COUNT];
  logic signed [CW-1:0] tick_rem [AXIS_COUNT];
  logic [CW-1:0] tick_cnt [AXIS_COUNT];
  logic [PAD-1:0] fire_pad;
  logic [1:0] code_pad [PAD];
  logic [5:0] latch_next;

  assign cmd_stall = (state != S_IDLE);
  assign cur_mag   = magnitude(remaining[idx]);
  assign is_last   = (idx == LAST_IDX);

  always_comb begin
    sum = SUM_W'(remaining[idx]) + SUM_W'(add_steps);
    if (sum > SAT_HI) begin
      sat_sum = CW'(SAT_HI);
    end else if (sum < SAT_LO) begin
      sat_sum = CW'(SAT_LO);
    end else begin
      sat_sum = CW'(sum);
    end
  end

  always_comb begin
    shifted = {partial, quotient[CW-1]};
    trial   = shifted - {1'b0, divisor};
    if (!trial[CW]) begin
      partial_next  = trial[CW-1:0];
      quotient_next = {quotient[CW-2:0], 1'b1};
    end else begin
      partial_next  = shifted[CW-1:0];
      quotient_next = {quotient[CW-2:0], 1'b0};
    end
  end

  always_comb begin
    logic [CW-1:0] inc;
    logic [1:0] back;
    fire_pad = '0;
    for (int p = 0; p < PAD; p++) begin
      code_pad[p] = 2'd0;
    end
    all_idle = 1'b1;
    for (int a = 0; a < AXIS_COUNT; a++) begin
      inc           = counter[a] + 1'b1;
      back          = phase[a] - 2'd1;
      tick_phase[a] = phase[a];
      tick_rem[a]   = remaining[a];
      tick_cnt[a]   = counter[a];
      if (remaining[a] != '0) begin
        all_idle = 1'b0;
        if (inc < period[a]) begin
          tick_cnt[a] = inc;
        end else begin
          tick_cnt[a] = '0;
          fire_pad[a] = 1'b1;
          if (!remaining[a][CW-1]) begin
            code_pad[a]   = gray_code(phase[a]);
            tick_phase[a] = phase[a] + 2'd1;
            tick_rem[a]   = remaining[a] - 1'b1;
          end else begin
            code_pad[a]   = gray_code(back);
            tick_phase[a] = back;
            tick_rem[a]   = remaining[a] + 1'b1;
          end
        end
      end
    end
    latch_next = coil_latch;
    for (int p = 0; p < LATCH_PAIRS; p++) begin
      if (fire_pad[p]) begin
        latch_next[2*p +: 2] = code_pad[p];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_valid  <= 1'b0;
      coil_latch <= '0;
      idx        <= '0;
      for (int a = 0; a < AXIS_COUNT; a++) begin
        phase[a]     <= '0;
        remaining[a] <= '0;
        counter[a]   <= '0;
        period[a]    <= CW'(1);
      end
    end else begin
      if (res_valid && !res_stall && state != S_FINISH) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            add_steps <= cmd.steps;
            if (cmd.operation == OP_TICK) begin
              for (int a = 0; a < AXIS_COUNT; a++) begin
                phase[a]     <= tick_phase[a];
                remaining[a] <= tick_rem[a];
                counter[a]   <= tick_cnt[a];
              end
              coil_latch <= latch_next;
              state      <= S_FINISH;
            end else if (32'(cmd.axis) < AXIS_COUNT) begin
              idx   <= IDX_W'(cmd.axis);
              state <= S_ADD;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_ADD: begin
          remaining[idx] <= sat_sum;
          top            <= '0;
          idx            <= '0;
          state          <= S_SCAN;
        end
        S_SCAN: begin
          if (cur_mag > top) begin
            top <= cur_mag;
          end
          if (is_last) begin
            idx   <= '0;
            state <= S_DIV_LOAD;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_DIV_LOAD: begin
          counter[idx] <= '0;
          if (cur_mag == '0) begin
            period[idx] <= CW'(1);
            if (is_last) begin
              state <= S_FINISH;
            end else begin
              idx <= idx + 1'b1;
            end
          end else begin
            divisor   <= cur_mag;
            partial   <= '0;
            quotient  <= top;
            bits_left <= BIT_W'(CW);
            state     <= S_DIV_RUN;
          end
        end
        S_DIV_RUN: begin
          partial   <= partial_next;
          quotient  <= quotient_next;
          bits_left <= bits_left - 1'b1;
          if (bits_left == BIT_W'(1)) begin
            period[idx] <= quotient_next;
            if (is_last) begin
              state <= S_FINISH;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_DIV_LOAD;
            end
          end
        end
        S_FINISH: begin
          if (!res_valid || !res_stall) begin
            res_valid        <= 1'b1;
            res.coil_pattern <= coil_latch;
            res.idle         <= all_idle;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
